/* rtl/core/date_difference_days_macros.svh */
// assertion macros used by dd_checker
// no dependencies
`ifndef DATE_DIFFERENCE_DAYS_MACROS_SVH
`define DATE_DIFFERENCE_DAYS_MACROS_SVH

// same-cycle implication, disabled during reset
`define DD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dd assertion failed");

// next-cycle implication, disabled during reset
`define DD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dd assertion failed");

`endif

/* rtl/core/dd_pkg.sv */
// types, constants and calendar tables for the date difference block
// no dependencies
package dd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;
    localparam int NUM_W   = 23;   // day number, wide enough for any 14-bit year
    localparam int QUOT_W  = 8;    // (year - 1) / 100 for any 14-bit year
    localparam int REM_W   = 7;

    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [YEAR_W-1:0]  CENTURY    = 14'd100;
    localparam logic [REM_W-1:0]   LAST_OF_CENTURY = 7'd99;
    localparam logic [NUM_W-1:0]   YEAR_DAYS  = 23'd365;
    localparam logic [12:0]        RECIP_100  = 13'd5243;   // 2^19 / 100, rounded up
    localparam int                 RECIP_SHIFT = 19;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = 5'd29;

    typedef struct packed {
        logic [YEAR_W-1:0]  p;        // year - 1
        logic [QUOT_W-1:0]  qp;       // p / 100
        logic [NUM_W-1:0]   p365;     // p * 365
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               year_ok;
    } t_year_info;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

/* rtl/core/dd_date_unit.sv */
// two-stage date check and day number for one date
// depends on dd_pkg
module dd_date_unit (
    input  logic                        i_clk,
    input  logic [dd_pkg::YEAR_W-1:0]   i_year,
    input  logic [dd_pkg::MONTH_W-1:0]  i_month,
    input  logic [dd_pkg::DAY_W-1:0]    i_day,
    output logic [dd_pkg::NUM_W-1:0]    o_day_num,
    output logic                        o_ok
);

    localparam int PROD_W = dd_pkg::YEAR_W + 13;

    dd_pkg::t_year_info              r_s1, n_s1;
    logic [PROD_W-1:0]               w_prod;
    logic [dd_pkg::YEAR_W-1:0]       w_rem_full;
    logic [dd_pkg::REM_W-1:0]        w_rem;
    logic                            w_cent;
    logic                            w_leap;
    logic [dd_pkg::DAY_W-1:0]        w_len;
    logic                            w_month_ok;
    logic                            w_day_ok;
    logic [dd_pkg::NUM_W-1:0]        n_num, r_num;
    logic                            n_ok, r_ok;

    // stage 1: year - 1, its quotient by 100 via reciprocal, and whole-year days
    always_comb begin
        n_s1.p       = i_year - 14'd1;
        w_prod       = PROD_W'(n_s1.p) * PROD_W'(dd_pkg::RECIP_100);
        n_s1.qp      = w_prod[dd_pkg::RECIP_SHIFT +: dd_pkg::QUOT_W];
        n_s1.p365    = dd_pkg::NUM_W'(n_s1.p) * dd_pkg::YEAR_DAYS;
        n_s1.month   = i_month;
        n_s1.day     = i_day;
        n_s1.year_ok = (i_year != '0) && (i_year <= dd_pkg::YEAR_MAX);
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    // stage 2: leap rule, validity and day number
    always_comb begin
        w_rem_full = r_s1.p - (dd_pkg::YEAR_W'(r_s1.qp) * dd_pkg::CENTURY);
        w_rem      = w_rem_full[dd_pkg::REM_W-1:0];
        // year is a multiple of 100 when year - 1 ends in 99
        w_cent     = (w_rem == dd_pkg::LAST_OF_CENTURY);
        // multiple of 400 when (year - 1) / 100 + 1 is a multiple of 4
        w_leap     = (r_s1.p[1:0] == 2'b11) && (!w_cent || (r_s1.qp[1:0] == 2'b11));
        w_len      = dd_pkg::month_len(r_s1.month);
        if ((r_s1.month == dd_pkg::MONTH_FEB) && w_leap) begin
            w_len = dd_pkg::FEB_LEAP_LEN;
        end
        w_month_ok = (r_s1.month inside {[dd_pkg::MONTH_JAN:dd_pkg::MONTH_DEC]});
        w_day_ok   = (r_s1.day != '0) && (r_s1.day <= w_len);
        n_ok       = r_s1.year_ok && w_month_ok && w_day_ok;
        n_num      = r_s1.p365
                   + dd_pkg::NUM_W'(r_s1.p[dd_pkg::YEAR_W-1:2])
                   - dd_pkg::NUM_W'(r_s1.qp)
                   + dd_pkg::NUM_W'(r_s1.qp[dd_pkg::QUOT_W-1:2])
                   + dd_pkg::NUM_W'(dd_pkg::days_before(r_s1.month))
                   + dd_pkg::NUM_W'(w_leap && (r_s1.month > dd_pkg::MONTH_FEB))
                   + dd_pkg::NUM_W'(r_s1.day);
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_ok  <= n_ok;
    end

    assign o_day_num = r_num;
    assign o_ok      = r_ok;

endmodule

/* rtl/core/date_difference_days.sv */
// top level of the gregorian date difference block
// depends on dd_pkg and dd_date_unit
//
// usage:
//   a transaction is taken at a rising edge with start high and busy low.
//   busy is tied low: the three-stage pipeline takes one date pair every
//   cycle, with no gaps between transactions.
//   each transaction gives one result, shown on o_date_error and
//   o_day_count for exactly one cycle while o_strobe is high.
//   the result strobe rises once the transaction has passed three
//   registered stages (stage 1 divides the year by 100 by reciprocal
//   multiply, stage 2 applies the leap rule and sums the day number,
//   stage 3 takes the absolute difference).
//   throughput: one transaction per cycle.
//   o_date_error is high when either date is invalid; o_day_count is then 0.
//   the receiver cannot hold results off, so nothing here ever stalls.
//   synchronous reset clears the valid pipeline; transactions in flight
//   are dropped and no strobe follows them.
module date_difference_days (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [dd_pkg::YEAR_W-1:0]    i_first_year,
    input  logic [dd_pkg::MONTH_W-1:0]   i_first_month,
    input  logic [dd_pkg::DAY_W-1:0]     i_first_day,
    input  logic [dd_pkg::YEAR_W-1:0]    i_second_year,
    input  logic [dd_pkg::MONTH_W-1:0]   i_second_month,
    input  logic [dd_pkg::DAY_W-1:0]     i_second_day,
    output logic                         o_strobe,
    output logic                         o_date_error,
    output logic [dd_pkg::COUNT_W-1:0]   o_day_count
);

    logic [dd_pkg::NUM_W-1:0]   w_num_a, w_num_b;
    logic                       w_ok_a, w_ok_b;
    logic [dd_pkg::NUM_W-1:0]   w_diff;
    logic                       r_v1, r_v2, r_v3;
    logic                       n_err;
    logic [dd_pkg::COUNT_W-1:0] n_count;
    logic                       r_err;
    logic [dd_pkg::COUNT_W-1:0] r_count;

    assign busy = 1'b0;

    dd_date_unit u_first (
        .i_clk     (i_clk),
        .i_year    (i_first_year),
        .i_month   (i_first_month),
        .i_day     (i_first_day),
        .o_day_num (w_num_a),
        .o_ok      (w_ok_a)
    );

    dd_date_unit u_second (
        .i_clk     (i_clk),
        .i_year    (i_second_year),
        .i_month   (i_second_month),
        .i_day     (i_second_day),
        .o_day_num (w_num_b),
        .o_ok      (w_ok_b)
    );

    // valid bits travel alongside the date units
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        w_diff  = (w_num_a >= w_num_b) ? (w_num_a - w_num_b) : (w_num_b - w_num_a);
        n_err   = !(w_ok_a && w_ok_b);
        n_count = n_err ? '0 : w_diff[dd_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_err   <= n_err;
        r_count <= n_count;
    end

    assign o_strobe     = r_v3;
    assign o_date_error = r_err;
    assign o_day_count  = r_count;

endmodule

/* rtl/core/dd_checker.sv */
// port-level checks for date_difference_days, bound to the top level
// depends on dd_pkg and date_difference_days_macros.svh
`include "date_difference_days_macros.svh"

module dd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [dd_pkg::YEAR_W-1:0]    i_first_year,
    input logic [dd_pkg::MONTH_W-1:0]   i_first_month,
    input logic [dd_pkg::DAY_W-1:0]     i_first_day,
    input logic [dd_pkg::YEAR_W-1:0]    i_second_year,
    input logic [dd_pkg::MONTH_W-1:0]   i_second_month,
    input logic [dd_pkg::DAY_W-1:0]     i_second_day,
    input logic                         o_strobe,
    input logic                         o_date_error,
    input logic [dd_pkg::COUNT_W-1:0]   o_day_count
);

    // every accepted transaction gets its result strobe
    `DD_ASSERT_NOW(a_result_follows, i_clk, i_rst_n, start && !busy, ##3 o_strobe)

    // no result strobe without an earlier accepted transaction
    `DD_ASSERT_NOW(a_no_spurious, i_clk, i_rst_n, o_strobe, $past(start, 3) && !$past(busy, 3))

    // an invalid date reports zero days
    `DD_ASSERT_NOW(a_error_zero, i_clk, i_rst_n, o_strobe && o_date_error, o_day_count == '0)

    // identical dates are zero days apart
    `DD_ASSERT_NOW(a_same_date, i_clk, i_rst_n,
        start && !busy && (i_first_year == i_second_year)
            && (i_first_month == i_second_month) && (i_first_day == i_second_day),
        ##3 (o_day_count == '0))

endmodule

bind date_difference_days dd_checker u_dd_checker (.*);

/* bench/date_difference_days_checker.sv */
`timescale 1ns / 100ps
// result checker for date_difference_days: computes the day gap of each
// accepted date pair and compares it with the strobed results; uses dd_pkg
module date_difference_days_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic [dd_pkg::YEAR_W-1:0]    i_first_year,
    input  logic [dd_pkg::MONTH_W-1:0]   i_first_month,
    input  logic [dd_pkg::DAY_W-1:0]     i_first_day,
    input  logic [dd_pkg::YEAR_W-1:0]    i_second_year,
    input  logic [dd_pkg::MONTH_W-1:0]   i_second_month,
    input  logic [dd_pkg::DAY_W-1:0]     i_second_day,
    input  logic                         i_strobe,
    input  logic                         i_date_error,
    input  logic [dd_pkg::COUNT_W-1:0]   i_day_count,
    output int                           o_fail_count,
    output int                           o_waiting,
    output int                           o_checked,
    output int                           o_flagged
);

    typedef struct packed {
        logic [31:0]                 serial;
        logic                        date_error;
        logic [dd_pkg::COUNT_W-1:0]  day_count;
    } t_day_gap;

    t_day_gap pending_gaps[$];
    int       fail_total    = 0;
    int       checked_total = 0;
    int       flagged_total = 0;
    int       taken_total   = 0;

    assign o_fail_count = fail_total;
    assign o_checked    = checked_total;
    assign o_flagged    = flagged_total;

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        int unsigned len;
        case (m)
            2:                      len = is_leap(y) ? 29 : 28;
            4, 6, 9, 11:            len = 30;
            1, 3, 5, 7, 8, 10, 12:  len = 31;
            default:                len = 0;
        endcase
        return len;
    endfunction

    // a bad month gives length 0, so any day fails the range check
    function automatic bit date_valid(input int unsigned y, input int unsigned m,
                                      input int unsigned d);
        return y >= 1 && y <= int'(dd_pkg::YEAR_MAX) && d >= 1 && d <= days_in_month(y, m);
    endfunction

    // day serial with 0001-01-01 as day 1
    function automatic int unsigned serial_day(input int unsigned y, input int unsigned m,
                                               input int unsigned d);
        int unsigned prior;
        int unsigned total;
        int unsigned k;
        prior = y - 1;
        total = prior * 365 + prior / 4 - prior / 100 + prior / 400 + d;
        for (k = 1; k < m; k++)
            total += days_in_month(y, k);
        return total;
    endfunction

    function automatic t_day_gap predict_gap(
        input logic [dd_pkg::YEAR_W-1:0]  y1,
        input logic [dd_pkg::MONTH_W-1:0] m1,
        input logic [dd_pkg::DAY_W-1:0]   d1,
        input logic [dd_pkg::YEAR_W-1:0]  y2,
        input logic [dd_pkg::MONTH_W-1:0] m2,
        input logic [dd_pkg::DAY_W-1:0]   d2
    );
        t_day_gap    gap;
        int unsigned a;
        int unsigned b;
        gap = '0;
        if (!date_valid(y1, m1, d1) || !date_valid(y2, m2, d2)) begin
            gap.date_error = 1'b1;
        end else begin
            a = serial_day(y1, m1, d1);
            b = serial_day(y2, m2, d2);
            gap.day_count = dd_pkg::COUNT_W'((a > b) ? (a - b) : (b - a));
        end
        return gap;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] serial,
                                   input logic [31:0] want, input logic [31:0] got);
        fail_total++;
        if (fail_total <= 10)
            $display("[%0t] mismatch on %s, transaction %0d: expected %0d, got %0d",
                     $time, what, serial, want, got);
    endtask

    always @(posedge i_clk) begin : watch
        t_day_gap want;
        if (!i_rst_n) begin
            pending_gaps.delete();
            o_waiting <= 0;
        end else begin
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                want = predict_gap(i_first_year, i_first_month, i_first_day,
                                   i_second_year, i_second_month, i_second_day);
                want.serial = taken_total;
                taken_total++;
                pending_gaps.push_back(want);
            end
            if ($isunknown(i_strobe)) begin
                report_mismatch("strobe", 0, 0, i_strobe);
            end else if (i_strobe) begin
                if (pending_gaps.size() == 0) begin
                    report_mismatch("unrequested strobe", 0, 0, 1);
                end else begin
                    want = pending_gaps.pop_front();
                    checked_total++;
                    if (want.date_error)
                        flagged_total++;
                    if (i_date_error !== want.date_error)
                        report_mismatch("date_error", want.serial, want.date_error,
                                        i_date_error);
                    if (i_day_count !== want.day_count)
                        report_mismatch("day_count", want.serial, want.day_count,
                                        i_day_count);
                end
            end
            o_waiting <= pending_gaps.size();
        end
    end

endmodule

/* bench/date_difference_days_tb.sv */
`timescale 1ns / 100ps
// top of the date_difference_days bench: reset, clock, date pair stimulus
// and verdict; depends on dd_pkg, the block and date_difference_days_checker
module date_difference_days_tb;

    localparam int RANDOM_ITEMS = 700;
    localparam int CALM_TAIL    = 100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 8;

    typedef enum {PICK_VALID, PICK_CENTURY_EDGE, PICK_NOISE} t_pick_kind;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [dd_pkg::YEAR_W-1:0]    i_first_year;
    logic [dd_pkg::MONTH_W-1:0]   i_first_month;
    logic [dd_pkg::DAY_W-1:0]     i_first_day;
    logic [dd_pkg::YEAR_W-1:0]    i_second_year;
    logic [dd_pkg::MONTH_W-1:0]   i_second_month;
    logic [dd_pkg::DAY_W-1:0]     i_second_day;
    logic                         o_strobe;
    logic                         o_date_error;
    logic [dd_pkg::COUNT_W-1:0]   o_day_count;

    int fail_count;
    int waiting;
    int checked;
    int flagged;
    int cycle_count = 0;
    int sent        = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    date_difference_days u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_first_year   (i_first_year),
        .i_first_month  (i_first_month),
        .i_first_day    (i_first_day),
        .i_second_year  (i_second_year),
        .i_second_month (i_second_month),
        .i_second_day   (i_second_day),
        .o_strobe       (o_strobe),
        .o_date_error   (o_date_error),
        .o_day_count    (o_day_count)
    );

    date_difference_days_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_first_year   (i_first_year),
        .i_first_month  (i_first_month),
        .i_first_day    (i_first_day),
        .i_second_year  (i_second_year),
        .i_second_month (i_second_month),
        .i_second_day   (i_second_day),
        .i_strobe       (o_strobe),
        .i_date_error   (o_date_error),
        .i_day_count    (o_day_count),
        .o_fail_count   (fail_count),
        .o_waiting      (waiting),
        .o_checked      (checked),
        .o_flagged      (flagged)
    );

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, waiting);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_dates(
        input logic [dd_pkg::YEAR_W-1:0]  y1,
        input logic [dd_pkg::MONTH_W-1:0] m1,
        input logic [dd_pkg::DAY_W-1:0]   d1,
        input logic [dd_pkg::YEAR_W-1:0]  y2,
        input logic [dd_pkg::MONTH_W-1:0] m2,
        input logic [dd_pkg::DAY_W-1:0]   d2
    );
        start          <= 1'b1;
        i_first_year   <= y1;
        i_first_month  <= m1;
        i_first_day    <= d1;
        i_second_year  <= y2;
        i_second_month <= m2;
        i_second_day   <= d2;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        sent++;
    endtask

    task automatic idle_for(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // the checker count is registered at each edge, so look only after the next edge
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
    endtask

    task automatic pick_date(
        input  t_pick_kind                 kind,
        output logic [dd_pkg::YEAR_W-1:0]  y,
        output logic [dd_pkg::MONTH_W-1:0] m,
        output logic [dd_pkg::DAY_W-1:0]   d
    );
        case (kind)
            PICK_VALID: begin
                y = dd_pkg::YEAR_W'($urandom_range(1, 9999));
                m = dd_pkg::MONTH_W'($urandom_range(1, 12));
                // month ends now and then, some of them past the real end
                d = dd_pkg::DAY_W'(($urandom_range(0, 3) == 0) ? $urandom_range(29, 31)
                                                                : $urandom_range(1, 28));
            end
            PICK_CENTURY_EDGE: begin
                y = dd_pkg::YEAR_W'($urandom_range(1, 99) * 100 - $urandom_range(0, 1));
                m = dd_pkg::MONTH_W'(($urandom_range(0, 3) == 0) ? 12 : $urandom_range(1, 3));
                d = dd_pkg::DAY_W'(($urandom_range(0, 1) == 0) ? 1 : $urandom_range(27, 31));
            end
            default: begin
                y = dd_pkg::YEAR_W'($urandom_range(0, 16383));
                m = dd_pkg::MONTH_W'($urandom_range(0, 15));
                d = dd_pkg::DAY_W'($urandom_range(0, 31));
            end
        endcase
    endtask

    initial begin
        logic [dd_pkg::YEAR_W-1:0]  y1;
        logic [dd_pkg::YEAR_W-1:0]  y2;
        logic [dd_pkg::MONTH_W-1:0] m1;
        logic [dd_pkg::MONTH_W-1:0] m2;
        logic [dd_pkg::DAY_W-1:0]   d1;
        logic [dd_pkg::DAY_W-1:0]   d2;
        int                         mix;

        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_first_year   <= '0;
        i_first_month  <= '0;
        i_first_day    <= '0;
        i_second_year  <= '0;
        i_second_month <= '0;
        i_second_day   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: full span both ways, bad fields, leap rules, equal dates
        send_dates(1, 1, 1, 9999, 12, 31);
        send_dates(9999, 12, 31, 1, 1, 1);
        send_dates(2024, 3, 15, 2024, 3, 15);
        send_dates(0, 1, 1, 2000, 1, 1);
        send_dates(2000, 1, 1, 10000, 1, 1);
        send_dates(16383, 12, 31, 1, 1, 1);
        send_dates(2000, 0, 1, 2000, 1, 1);
        send_dates(2000, 1, 1, 2000, 13, 1);
        send_dates(2000, 15, 31, 2000, 1, 1);
        send_dates(2000, 1, 0, 2000, 1, 1);
        send_dates(2001, 4, 31, 2001, 5, 1);
        send_dates(2000, 2, 29, 2000, 3, 1);
        send_dates(1900, 2, 29, 1900, 3, 1);
        send_dates(2004, 2, 29, 2003, 2, 28);
        send_dates(2001, 2, 29, 2001, 2, 28);
        send_dates(2100, 2, 28, 2100, 3, 1);
        send_dates(1999, 12, 31, 2000, 1, 1);
        send_dates(9999, 12, 31, 9999, 12, 31);
        send_dates(8191, 7, 16, 4096, 8, 31);
        send_dates(1, 1, 1, 1, 1, 1);
        send_dates(2000, 1, 31, 2000, 12, 31);
        send_dates(2023, 6, 30, 2024, 2, 29);
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            mix = $urandom_range(0, 99);
            if (mix < 55) begin
                pick_date(PICK_VALID, y1, m1, d1);
                pick_date(PICK_VALID, y2, m2, d2);
            end else if (mix < 72) begin
                pick_date(PICK_CENTURY_EDGE, y1, m1, d1);
                pick_date(PICK_CENTURY_EDGE, y2, m2, d2);
                y2 = dd_pkg::YEAR_W'(y1 + $urandom_range(0, 1));
            end else if (mix < 82) begin
                // same date, or the next day number written the same way
                pick_date(PICK_VALID, y1, m1, d1);
                y2 = y1;
                m2 = m1;
                d2 = dd_pkg::DAY_W'(d1 + $urandom_range(0, 1));
            end else if (mix < 90) begin
                pick_date(PICK_VALID, y1, m1, d1);
                pick_date(PICK_NOISE, y2, m2, d2);
            end else begin
                pick_date(PICK_NOISE, y1, m1, d1);
                pick_date(PICK_NOISE, y2, m2, d2);
            end
            send_dates(y1, m1, d1, y2, m2, d2);
            if (i == RANDOM_ITEMS / 2)
                drain();
            else if (i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 7));
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);

        $display("%0d date pairs sent, %0d results checked, %0d of them invalid dates",
                 sent, checked, flagged);
        $display("covered field extremes, leap and century rules, equal and reversed dates");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
